// ===== hw/rtl/lzc_pkg.sv =====
// Shared types and constants of the LZ chunk stream decompressor.
package lzc_pkg;

   // Fixed header geometry and magic pattern.
   localparam int HEADER_BYTES = 16;
   localparam int MAGIC_BYTES = 8;
   localparam int SIZE_FIELD_START = 12;
   localparam int MAX_GROUP = 4;
   localparam int OFFSET_WIDTH = 15;
   localparam logic [7:0] MAGIC [MAGIC_BYTES] = '{
      8'h2E, 8'h53, 8'h51, 8'h5A, 8'h2E, 8'h62, 8'h6D, 8'h70
   };

   // Result status codes.
   typedef enum logic [2:0] {
      STATUS_DATA     = 3'd0,
      STATUS_DONE     = 3'd1,
      STATUS_SHORT    = 3'd2,
      STATUS_BADHDR   = 3'd3,
      STATUS_TRUNC    = 3'd4,
      STATUS_OVERFLOW = 3'd5,
      STATUS_BADOFF   = 3'd6
   } status_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic accept;
      logic hdr_step;
      logic load_first;
      logic load_word;
      logic load_second;
      logic load_litrun;
      logic dec_rem;
      logic dec_lit;
      logic emit_lit;
      logic start_short;
      logic start_long;
      logic mem_rd;
      logic emit_match;
      logic push_group;
      logic push_status;
      logic push_last;
      logic clear_all;
      status_type status;
   } dp_cmd_type;

   // Status flags from the datapath to the controller.
   typedef struct packed {
      logic magic_bad;
      logic hdr_final;
      logic word_neg;
      logic word_zero;
      logic rem_le1;
      logic rem_zero;
      logic chunk_lit;
      logic byte_msb;
      logic lit_last;
      logic short_bad;
      logic long_bad;
      logic full;
      logic size_equal;
      logic match_last;
      logic grp_full;
      logic grp_empty;
      logic out_free;
      logic eos;
   } dp_status_type;

endpackage

// ===== hw/rtl/lzc_chan_if.sv =====
// Handshake channels for compressed input words and decompressed result words.
interface lzc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       end_of_stream;

   modport source(output valid, in_byte, end_of_stream, input ready);
   modport sink(input valid, in_byte, end_of_stream, output ready);
endinterface

interface lzc_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] byte_0;
   logic [7:0] byte_1;
   logic [7:0] byte_2;
   logic [7:0] byte_3;
   logic [2:0] byte_count;
   logic [2:0] status;
   logic       last_of_run;

   modport source(output valid, byte_0, byte_1, byte_2, byte_3, byte_count, status,
      last_of_run, input ready);
   modport sink(input valid, byte_0, byte_1, byte_2, byte_3, byte_count, status,
      last_of_run, output ready);
endinterface

// ===== hw/rtl/lz_chunk_stream_decompressor_core.sv =====
// Top level of the LZ chunk stream decompressor.
//
// req_chan carries the compressed file one byte per word, with end_of_stream
// on its last byte. rsp_chan returns result words of up to four decompressed
// bytes, or status words with byte_count 0; last_of_run marks the final result
// caused by one input byte.
// Each input byte passes through the decode, flush, error-status and end-of-stream
// states before the block is ready again, and every byte that a match copies adds a history
// read state and a write state on the window memory (one write port, one read port). A literal
// byte enters the group buffer when decoded and reaches the output register in the flush state.
// Result words pass through one output register; while the receiver stalls
// with that register full, the sequencer waits before loading the next word,
// and no new input byte is accepted until the current one is fully handled.
// Reset returns the parser to the header phase with its control counters cleared; the
// history window needs no clearing, as only written entries are ever read.
// After an end-of-stream byte the block rearms for a new file.
module lz_chunk_stream_decompressor_core
   import lzc_pkg::*;
#(
   parameter int WINDOW_SIZE = 32768,
   parameter int BYTES_PER_RESULT = 4
) (
   input logic           clock,
   input logic           reset,
   lzc_req_if.sink       req_chan,
   lzc_rsp_if.source     rsp_chan
);

   dp_cmd_type    cmd;
   dp_status_type st;
   status_type    rsp_status;

   lzc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .st        (st),
      .cmd       (cmd)
   );

   lzc_dp #(
      .WINDOW_SIZE      (WINDOW_SIZE),
      .BYTES_PER_RESULT (BYTES_PER_RESULT)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .st                (st),
      .req_in_byte       (req_chan.in_byte),
      .req_end_of_stream (req_chan.end_of_stream),
      .rsp_valid         (rsp_chan.valid),
      .rsp_ready         (rsp_chan.ready),
      .rsp_byte_0        (rsp_chan.byte_0),
      .rsp_byte_1        (rsp_chan.byte_1),
      .rsp_byte_2        (rsp_chan.byte_2),
      .rsp_byte_3        (rsp_chan.byte_3),
      .rsp_byte_count    (rsp_chan.byte_count),
      .rsp_status        (rsp_status),
      .rsp_last_of_run   (rsp_chan.last_of_run)
   );

   assign rsp_chan.status = rsp_status;

endmodule

// ===== hw/rtl/lzc_dp.sv =====
// Datapath of the decompressor: parse registers, history memory, grouping and output register.
module lzc_dp
   import lzc_pkg::*;
#(
   parameter int WINDOW_SIZE = 32768,
   parameter int BYTES_PER_RESULT = 4
) (
   input  logic          clock,
   input  logic          reset,
   input  dp_cmd_type    cmd,
   output dp_status_type st,
   input  logic [7:0]    req_in_byte,
   input  logic          req_end_of_stream,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output logic [7:0]    rsp_byte_0,
   output logic [7:0]    rsp_byte_1,
   output logic [7:0]    rsp_byte_2,
   output logic [7:0]    rsp_byte_3,
   output logic [2:0]    rsp_byte_count,
   output status_type    rsp_status,
   output logic          rsp_last_of_run
);

   localparam int AW = $clog2(WINDOW_SIZE);
   localparam int GROUP = (BYTES_PER_RESULT > MAX_GROUP) ? MAX_GROUP : BYTES_PER_RESULT;

   logic [7:0]              byte_ff, byte_in;
   logic                    eos_ff, eos_in;
   logic [4:0]              hdr_idx_ff, hdr_idx_in;
   logic [31:0]             declared_ff, declared_in;
   logic [15:0]             rem_ff, rem_in;
   logic                    chunk_lit_ff, chunk_lit_in;
   logic [7:0]              tok_first_ff, tok_first_in;
   logic [7:0]              tok_second_ff, tok_second_in;
   logic [7:0]              lit_left_ff, lit_left_in;
   logic [31:0]             bw_ff, bw_in;
   logic [AW-1:0]           wr_idx_ff, wr_idx_in;
   logic [7:0]              match_left_ff, match_left_in;
   logic [OFFSET_WIDTH-1:0] match_off_ff, match_off_in;
   logic [7:0]              grp_ff [MAX_GROUP];
   logic [7:0]              grp_in [MAX_GROUP];
   logic [2:0]              grp_n_ff, grp_n_in;
   logic                    out_valid_ff, out_valid_in;
   logic [7:0]              out_byte_ff [MAX_GROUP];
   logic [7:0]              out_byte_in [MAX_GROUP];
   logic [2:0]              out_count_ff, out_count_in;
   status_type              out_status_ff, out_status_in;
   logic                    out_last_ff, out_last_in;
   logic [7:0]              rd_data_ff;
   logic [7:0]              hist_mem [WINDOW_SIZE];

   logic [15:0]             word;
   logic [10:0]             short_off;
   logic [14:0]             long_off;
   logic [AW:0]             rd_diff;
   logic [AW-1:0]           rd_idx;
   logic                    emit;
   logic [7:0]              emit_val;
   logic                    push_data;
   logic                    push_any;
   logic [7:0]              grp_masked [MAX_GROUP];

   // Decoded fields of the current word.
   assign word      = {byte_ff, tok_first_ff};
   assign short_off = {byte_ff[6:0], tok_first_ff[3:0]};
   assign long_off  = {tok_second_ff[6:0], byte_ff};

   // Read address trails the write pointer by the match offset, wrapping in the window.
   assign rd_diff = {1'b0, wr_idx_ff} - (AW + 1)'(match_off_ff);
   assign rd_idx  = rd_diff[AW] ? AW'(rd_diff + (AW + 1)'(WINDOW_SIZE)) : rd_diff[AW-1:0];

   assign emit     = cmd.emit_lit || cmd.emit_match;
   assign emit_val = cmd.emit_lit ? byte_ff :
                     ((match_off_ff == '0) ? 8'd0 : rd_data_ff);

   // Status towards the controller.
   always_comb begin
      st.magic_bad  = (hdr_idx_ff < 5'(MAGIC_BYTES)) && (byte_ff != MAGIC[hdr_idx_ff[2:0]]);
      st.hdr_final  = hdr_idx_ff == 5'(HEADER_BYTES - 1);
      st.word_neg   = byte_ff[7];
      st.word_zero  = word == 16'd0;
      st.rem_le1    = rem_ff <= 16'd1;
      st.rem_zero   = rem_ff == 16'd0;
      st.chunk_lit  = chunk_lit_ff;
      st.byte_msb   = byte_ff[7];
      st.lit_last   = lit_left_ff <= 8'd1;
      st.short_bad  = 32'(short_off) > bw_ff;
      st.long_bad   = 32'(long_off) > bw_ff;
      st.full       = bw_ff >= declared_ff;
      st.size_equal = bw_ff == declared_ff;
      st.match_last = match_left_ff == 8'd1;
      st.grp_full   = grp_n_ff == 3'(GROUP);
      st.grp_empty  = grp_n_ff == 3'd0;
      st.out_free   = !out_valid_ff || rsp_ready;
      st.eos        = eos_ff;
   end

   // Group bytes beyond the fill level read as zero.
   always_comb begin
      for (int i = 0; i < MAX_GROUP; i++) begin
         grp_masked[i] = (3'(i) < grp_n_ff) ? grp_ff[i] : 8'd0;
      end
   end

   assign push_data = cmd.push_group || (emit && st.grp_full);
   assign push_any  = push_data || cmd.push_status;

   // Next state of the parse registers, group buffer and output register.
   always_comb begin
      byte_in       = byte_ff;
      eos_in        = eos_ff;
      hdr_idx_in    = hdr_idx_ff;
      declared_in   = declared_ff;
      rem_in        = rem_ff;
      chunk_lit_in  = chunk_lit_ff;
      tok_first_in  = tok_first_ff;
      tok_second_in = tok_second_ff;
      lit_left_in   = lit_left_ff;
      bw_in         = bw_ff;
      wr_idx_in     = wr_idx_ff;
      match_left_in = match_left_ff;
      match_off_in  = match_off_ff;
      grp_in        = grp_ff;
      grp_n_in      = grp_n_ff;
      out_valid_in  = out_valid_ff && !rsp_ready;
      out_byte_in   = out_byte_ff;
      out_count_in  = out_count_ff;
      out_status_in = out_status_ff;
      out_last_in   = out_last_ff;

      if (cmd.accept) begin
         byte_in = req_in_byte;
         eos_in  = req_end_of_stream;
      end

      // Header: count bytes and gather the little-endian size field.
      if (cmd.hdr_step) begin
         hdr_idx_in = hdr_idx_ff + 5'd1;
         if (hdr_idx_ff >= 5'(SIZE_FIELD_START)) begin
            declared_in[8*hdr_idx_ff[1:0] +: 8] = byte_ff;
         end
      end

      if (cmd.load_first) begin
         tok_first_in = byte_ff;
      end
      if (cmd.load_second) begin
         tok_second_in = byte_ff;
      end

      // Chunk word: negative words open a literal chunk.
      if (cmd.load_word) begin
         if (byte_ff[7]) begin
            rem_in       = 16'(17'h10000 - 17'(word));
            chunk_lit_in = 1'b1;
         end else begin
            rem_in       = word;
            chunk_lit_in = 1'b0;
         end
      end

      if (cmd.dec_rem && (rem_ff != 16'd0)) begin
         rem_in = rem_ff - 16'd1;
      end

      if (cmd.load_litrun) begin
         lit_left_in = byte_ff + 8'd1;
      end
      if (cmd.dec_lit && (lit_left_ff != 8'd0)) begin
         lit_left_in = lit_left_ff - 8'd1;
      end

      if (cmd.start_short) begin
         match_left_in = {5'd0, tok_first_ff[6:4]} + 8'd3;
         match_off_in  = OFFSET_WIDTH'(short_off);
      end
      if (cmd.start_long) begin
         match_left_in = {1'b0, tok_first_ff[6:0]} + 8'd3;
         match_off_in  = long_off;
      end
      if (cmd.emit_match) begin
         match_left_in = match_left_ff - 8'd1;
      end

      // Output register load: a data group or a status word.
      if (push_any) begin
         out_valid_in = 1'b1;
         if (push_data) begin
            out_byte_in   = grp_masked;
            out_count_in  = grp_n_ff;
            out_status_in = STATUS_DATA;
            out_last_in   = cmd.push_group && cmd.push_last;
         end else begin
            for (int i = 0; i < MAX_GROUP; i++) begin
               out_byte_in[i] = 8'd0;
            end
            out_count_in  = 3'd0;
            out_status_in = cmd.status;
            out_last_in   = cmd.push_last;
         end
      end

      if (cmd.push_group) begin
         grp_n_in = 3'd0;
      end

      // Emitted byte enters the history and the group buffer.
      if (emit) begin
         bw_in     = bw_ff + 32'd1;
         wr_idx_in = (wr_idx_ff == AW'(WINDOW_SIZE - 1)) ? '0 : wr_idx_ff + 1'b1;
         if (st.grp_full) begin
            grp_in[0] = emit_val;
            grp_n_in  = 3'd1;
         end else begin
            grp_in[grp_n_ff[1:0]] = emit_val;
            grp_n_in              = grp_n_ff + 3'd1;
         end
      end

      // End of file: rearm for the next header.
      if (cmd.clear_all) begin
         hdr_idx_in    = 5'd0;
         declared_in   = 32'd0;
         rem_in        = 16'd0;
         chunk_lit_in  = 1'b0;
         tok_first_in  = 8'd0;
         tok_second_in = 8'd0;
         lit_left_in   = 8'd0;
         bw_in         = 32'd0;
         wr_idx_in     = '0;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         hdr_idx_ff    <= 5'd0;
         declared_ff   <= 32'd0;
         rem_ff        <= 16'd0;
         chunk_lit_ff  <= 1'b0;
         tok_first_ff  <= 8'd0;
         tok_second_ff <= 8'd0;
         lit_left_ff   <= 8'd0;
         bw_ff         <= 32'd0;
         wr_idx_ff     <= '0;
         grp_n_ff      <= 3'd0;
         out_valid_ff  <= 1'b0;
      end else begin
         hdr_idx_ff    <= hdr_idx_in;
         declared_ff   <= declared_in;
         rem_ff        <= rem_in;
         chunk_lit_ff  <= chunk_lit_in;
         tok_first_ff  <= tok_first_in;
         tok_second_ff <= tok_second_in;
         lit_left_ff   <= lit_left_in;
         bw_ff         <= bw_in;
         wr_idx_ff     <= wr_idx_in;
         grp_n_ff      <= grp_n_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      byte_ff       <= byte_in;
      eos_ff        <= eos_in;
      match_left_ff <= match_left_in;
      match_off_ff  <= match_off_in;
      grp_ff        <= grp_in;
      out_byte_ff   <= out_byte_in;
      out_count_ff  <= out_count_in;
      out_status_ff <= out_status_in;
      out_last_ff   <= out_last_in;
   end

   // History memory with one write port and a registered read port.
   always_ff @(posedge clock) begin
      if (emit) begin
         hist_mem[wr_idx_ff] <= emit_val;
      end
      if (cmd.mem_rd) begin
         rd_data_ff <= hist_mem[rd_idx];
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_byte_0      = out_byte_ff[0];
   assign rsp_byte_1      = out_byte_ff[1];
   assign rsp_byte_2      = out_byte_ff[2];
   assign rsp_byte_3      = out_byte_ff[3];
   assign rsp_byte_count  = out_count_ff;
   assign rsp_status      = out_status_ff;
   assign rsp_last_of_run = out_last_ff;

`ifndef ASSERT_OFF
   a_push_needs_room: assert property (@(posedge clock) disable iff (reset)
      push_any |-> st.out_free)
      else $error("result word loaded while the output register is occupied");

   a_group_bound: assert property (@(posedge clock) disable iff (reset)
      grp_n_ff <= 3'(GROUP))
      else $error("group buffer over its size");

   a_within_size: assert property (@(posedge clock) disable iff (reset)
      bw_ff <= declared_ff)
      else $error("more bytes written than the declared size");
`endif

endmodule

// ===== hw/rtl/lzc_ctrl.sv =====
// Controller of the decompressor: stream parse phase and per-word sequencing.
module lzc_ctrl
   import lzc_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  dp_status_type st,
   output dp_cmd_type    cmd
);

   typedef enum logic [6:0] {
      S_IDLE     = 7'b0000001,
      S_DECODE   = 7'b0000010,
      S_MATCH_RD = 7'b0000100,
      S_MATCH_WR = 7'b0001000,
      S_FLUSH    = 7'b0010000,
      S_ERROR    = 7'b0100000,
      S_EOS      = 7'b1000000
   } flow_type;

   typedef enum logic [7:0] {
      PH_HEADER  = 8'b00000001,
      PH_WORD_LO = 8'b00000010,
      PH_WORD_HI = 8'b00000100,
      PH_CHUNK   = 8'b00001000,
      PH_SECOND  = 8'b00010000,
      PH_THIRD   = 8'b00100000,
      PH_LITRUN  = 8'b01000000,
      PH_DRAIN   = 8'b10000000
   } phase_type;

   flow_type   state_ff, state_in;
   phase_type  phase_ff, phase_in;
   logic       err_ff, err_in;
   logic       pend_valid_ff, pend_valid_in;
   status_type pend_code_ff, pend_code_in;
   logic       raise;
   status_type raise_code;
   status_type eos_code;

   // Closing status of a file that ended without an error.
   always_comb begin
      if (phase_ff == PH_WORD_LO) begin
         eos_code = st.size_equal ? STATUS_DONE : STATUS_SHORT;
      end else if (phase_ff == PH_HEADER) begin
         eos_code = STATUS_BADHDR;
      end else begin
         eos_code = STATUS_TRUNC;
      end
   end

   // Sequencing of one input word.
   always_comb begin
      state_in      = state_ff;
      phase_in      = phase_ff;
      err_in        = err_ff;
      pend_valid_in = pend_valid_ff;
      pend_code_in  = pend_code_ff;
      raise         = 1'b0;
      raise_code    = STATUS_DATA;
      req_ready     = 1'b0;
      cmd           = '0;
      cmd.status    = STATUS_DATA;

      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = S_DECODE;
            end
         end
         S_DECODE: begin
            state_in = S_FLUSH;
            unique case (phase_ff)
               PH_HEADER: begin
                  if (st.magic_bad) begin
                     raise      = 1'b1;
                     raise_code = STATUS_BADHDR;
                  end else begin
                     cmd.hdr_step = 1'b1;
                     if (st.hdr_final) begin
                        phase_in = PH_WORD_LO;
                     end
                  end
               end
               PH_WORD_LO: begin
                  cmd.load_first = 1'b1;
                  phase_in       = PH_WORD_HI;
               end
               PH_WORD_HI: begin
                  cmd.load_word = 1'b1;
                  phase_in      = (!st.word_neg && st.word_zero) ? PH_WORD_LO : PH_CHUNK;
               end
               PH_CHUNK: begin
                  if (st.chunk_lit) begin
                     if (st.full) begin
                        raise      = 1'b1;
                        raise_code = STATUS_OVERFLOW;
                     end else begin
                        cmd.emit_lit = 1'b1;
                        cmd.dec_rem  = 1'b1;
                        if (st.rem_le1) begin
                           phase_in = PH_WORD_LO;
                        end
                     end
                  end else begin
                     cmd.dec_rem = 1'b1;
                     if (st.byte_msb) begin
                        cmd.load_first = 1'b1;
                        phase_in       = PH_SECOND;
                     end else begin
                        cmd.load_litrun = 1'b1;
                        phase_in        = PH_LITRUN;
                     end
                  end
               end
               PH_SECOND: begin
                  cmd.dec_rem = 1'b1;
                  if (st.byte_msb) begin
                     if (st.short_bad) begin
                        raise      = 1'b1;
                        raise_code = STATUS_BADOFF;
                     end else begin
                        cmd.start_short = 1'b1;
                        state_in        = S_MATCH_RD;
                     end
                  end else begin
                     cmd.load_second = 1'b1;
                     phase_in        = PH_THIRD;
                  end
               end
               PH_THIRD: begin
                  cmd.dec_rem = 1'b1;
                  if (st.long_bad) begin
                     raise      = 1'b1;
                     raise_code = STATUS_BADOFF;
                  end else begin
                     cmd.start_long = 1'b1;
                     state_in       = S_MATCH_RD;
                  end
               end
               PH_LITRUN: begin
                  cmd.dec_rem = 1'b1;
                  if (st.full) begin
                     raise      = 1'b1;
                     raise_code = STATUS_OVERFLOW;
                  end else begin
                     cmd.emit_lit = 1'b1;
                     cmd.dec_lit  = 1'b1;
                     if (st.lit_last) begin
                        phase_in = st.rem_le1 ? PH_WORD_LO : PH_CHUNK;
                     end
                  end
               end
               PH_DRAIN: begin
               end
               default: begin
               end
            endcase
         end
         S_MATCH_RD: begin
            cmd.mem_rd = 1'b1;
            state_in   = S_MATCH_WR;
         end
         S_MATCH_WR: begin
            if (st.full) begin
               raise      = 1'b1;
               raise_code = STATUS_OVERFLOW;
            end else if (!st.grp_full || st.out_free) begin
               cmd.emit_match = 1'b1;
               if (st.match_last) begin
                  phase_in = st.rem_zero ? PH_WORD_LO : PH_CHUNK;
                  state_in = S_FLUSH;
               end else begin
                  state_in = S_MATCH_RD;
               end
            end
         end
         S_FLUSH: begin
            if (st.grp_empty) begin
               state_in = S_ERROR;
            end else if (st.out_free) begin
               cmd.push_group = 1'b1;
               cmd.push_last  = !pend_valid_ff && !(st.eos && !err_ff);
               state_in       = S_ERROR;
            end
         end
         S_ERROR: begin
            if (!pend_valid_ff) begin
               state_in = S_EOS;
            end else if (st.out_free) begin
               cmd.push_status = 1'b1;
               cmd.push_last   = 1'b1;
               cmd.status      = pend_code_ff;
               pend_valid_in   = 1'b0;
               state_in        = S_EOS;
            end
         end
         S_EOS: begin
            if (!st.eos) begin
               state_in = S_IDLE;
            end else if (err_ff || st.out_free) begin
               if (!err_ff) begin
                  cmd.push_status = 1'b1;
                  cmd.push_last   = 1'b1;
                  cmd.status      = eos_code;
               end
               cmd.clear_all = 1'b1;
               phase_in      = PH_HEADER;
               err_in        = 1'b0;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // An error ends the work on this word and parks the parser until end of file.
      if (raise) begin
         err_in        = 1'b1;
         phase_in      = PH_DRAIN;
         pend_valid_in = 1'b1;
         pend_code_in  = raise_code;
         state_in      = S_FLUSH;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         phase_ff      <= PH_HEADER;
         err_ff        <= 1'b0;
         pend_valid_ff <= 1'b0;
         pend_code_ff  <= STATUS_DATA;
      end else begin
         state_ff      <= state_in;
         phase_ff      <= phase_in;
         err_ff        <= err_in;
         pend_valid_ff <= pend_valid_in;
         pend_code_ff  <= pend_code_in;
      end
   end

`ifndef ASSERT_OFF
   a_accept_decodes: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == S_DECODE))
      else $error("accepted word not decoded next cycle");

   a_no_emit_when_full: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit_lit || cmd.emit_match) |-> !st.full)
      else $error("byte emitted past the declared size");

   a_pending_is_error: assert property (@(posedge clock) disable iff (reset)
      pend_valid_ff |-> (err_ff && (phase_ff == PH_DRAIN)))
      else $error("pending error status without the error state");
`endif

endmodule
